[rtl/core/bdlp_pkg.sv]
// ----------------------------------------------------------------------------
// bdlp_pkg
// shared widths, reset values and register indexes of the debounce block
// ----------------------------------------------------------------------------
package bdlp_pkg;

	localparam int FIELD_W = 4;   // one bit per button in every tick field
	localparam int CNT_W   = 16;  // hold countdown and config register width
	localparam int CFG_IDX_W = 1;

	localparam logic [CNT_W-1:0] LONG_START_RST  = 16'd100;
	localparam logic [CNT_W-1:0] LONG_REPEAT_RST = 16'd50;

	// released pin level (active-low pins)
	localparam logic LEVEL_RELEASED = 1'b1;
	localparam logic LEVEL_PRESSED  = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LONG_START  = 1'b0,
		REG_LONG_REPEAT = 1'b1
	} cfg_reg_t;

	typedef logic [FIELD_W-1:0] btn_vec_t;
	typedef logic [CNT_W-1:0]   cnt_t;

endpackage

[rtl/core/bdlp_if.sv]
// ----------------------------------------------------------------------------
// bdlp channel interfaces
// valid/ready channels for tick items and result items
// ----------------------------------------------------------------------------
interface bdlp_tick_if;
	logic              valid;
	logic              ready;
	bdlp_pkg::btn_vec_t pin_levels;
	bdlp_pkg::btn_vec_t press_ack;
	bdlp_pkg::btn_vec_t long_ack;

	modport source (output valid, output pin_levels, output press_ack, output long_ack,
		input ready);
	modport sink (input valid, input pin_levels, input press_ack, input long_ack,
		output ready);
endinterface

interface bdlp_result_if;
	logic              valid;
	logic              ready;
	bdlp_pkg::btn_vec_t press_pending;
	bdlp_pkg::btn_vec_t long_pending;
	bdlp_pkg::btn_vec_t stable_pressed;

	modport source (output valid, output press_pending, output long_pending,
		output stable_pressed, input ready);
	modport sink (input valid, input press_pending, input long_pending,
		input stable_pressed, output ready);
endinterface

[rtl/core/button_debounce_long_press_top.sv]
// ----------------------------------------------------------------------------
// button_debounce_long_press_top
// three-sample debounce per button with sticky press flag and long-press repeat
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                       | handshake
//  tick     | in  | pin_levels, press_ack, long_ack               | valid/ready
//  res      | out | press_pending, long_pending, stable_pressed   | valid/ready
//  cfg      | in  | cfg_index, cfg_wdata                          | cfg_we
//
//  one tick accepted per cycle; its result appears in the result register
//  on the next cycle. button state is updated at the accepting edge.
//  a tick is taken whenever the result register is empty or being drained,
//  so a stalled sink holds one result and stops the tick channel.
//  arst_n clears all button state to released and the registers to 100 / 50.
// ----------------------------------------------------------------------------
module button_debounce_long_press_top #(
	parameter int NUM_BUTTONS = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	bdlp_tick_if.sink                              tick,
	bdlp_result_if.source                          res,
	input  logic                                   cfg_we,
	input  logic [bdlp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bdlp_pkg::CNT_W-1:0]             cfg_wdata
);

	localparam int FW = bdlp_pkg::FIELD_W;

	bdlp_pkg::cnt_t long_start_q;
	bdlp_pkg::cnt_t long_repeat_q;

	// the oldest sample is never compared again once shifted out, so two
	// stored samples plus the incoming level make up the three-sample window
	logic middle_q [NUM_BUTTONS];
	logic newest_q [NUM_BUTTONS];
	logic acc_q    [NUM_BUTTONS];
	bdlp_pkg::cnt_t cnt_q [NUM_BUTTONS];
	logic press_q  [NUM_BUTTONS];
	logic long_q   [NUM_BUTTONS];

	logic          tick_acc;
	logic          res_valid_q;
	bdlp_pkg::btn_vec_t press_pending_q, long_pending_q, stable_pressed_q;
	bdlp_pkg::btn_vec_t press_nx_vec, long_nx_vec, stable_nx_vec;
	bdlp_pkg::btn_vec_t press_vis, long_vis, stable_vis;

	assign tick.ready = !res_valid_q || res.ready;
	assign tick_acc   = tick.valid && tick.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_start_q  <= bdlp_pkg::LONG_START_RST;
			long_repeat_q <= bdlp_pkg::LONG_REPEAT_RST;
		end else if (cfg_we) begin
			unique case (bdlp_pkg::cfg_reg_t'(cfg_index))
				bdlp_pkg::REG_LONG_START:  long_start_q  <= cfg_wdata;
				bdlp_pkg::REG_LONG_REPEAT: long_repeat_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
		logic           level;
		logic           pack, lack;
		logic           stable;
		logic           press_nx, long_nx, acc_nx;
		bdlp_pkg::cnt_t cnt_nx;
		bdlp_pkg::cnt_t cnt_dec;

		// buttons past the field width read zero bits, i.e. pressed
		if (g < FW) begin : g_vis
			assign level = tick.pin_levels[g];
			assign pack  = tick.press_ack[g];
			assign lack  = tick.long_ack[g];
		end else begin : g_hid
			assign level = bdlp_pkg::LEVEL_PRESSED;
			assign pack  = 1'b0;
			assign lack  = 1'b0;
		end

		assign stable  = (middle_q[g] == newest_q[g]) && (newest_q[g] == level);
		assign cnt_dec = cnt_q[g] - 1'b1;

		always_comb begin
			// acks clear first, the debounce update may set again
			press_nx = press_q[g] && !pack;
			long_nx  = long_q[g] && !lack;
			acc_nx   = acc_q[g];
			cnt_nx   = cnt_q[g];
			if (stable && (acc_q[g] != level)) begin
				acc_nx  = level;
				long_nx = 1'b0;
				if (level == bdlp_pkg::LEVEL_PRESSED) begin
					press_nx = 1'b1;
					cnt_nx   = long_start_q;
				end else begin
					cnt_nx   = '0;
				end
			end else if (stable && (level == bdlp_pkg::LEVEL_PRESSED) && (cnt_q[g] != '0)) begin
				if (cnt_dec == '0) begin
					long_nx = 1'b1;
					cnt_nx  = long_repeat_q;
				end else begin
					cnt_nx  = cnt_dec;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				middle_q[g] <= bdlp_pkg::LEVEL_RELEASED;
				newest_q[g] <= bdlp_pkg::LEVEL_RELEASED;
				acc_q[g]    <= bdlp_pkg::LEVEL_RELEASED;
				cnt_q[g]    <= '0;
				press_q[g]  <= 1'b0;
				long_q[g]   <= 1'b0;
			end else if (tick_acc) begin
				middle_q[g] <= newest_q[g];
				newest_q[g] <= level;
				acc_q[g]    <= acc_nx;
				cnt_q[g]    <= cnt_nx;
				press_q[g]  <= press_nx;
				long_q[g]   <= long_nx;
			end
		end

		if (g < FW) begin : g_out
			assign press_nx_vec[g]  = press_nx;
			assign long_nx_vec[g]   = long_nx;
			assign stable_nx_vec[g] = (acc_nx == bdlp_pkg::LEVEL_PRESSED);
			assign press_vis[g]     = press_q[g];
			assign long_vis[g]      = long_q[g];
			assign stable_vis[g]    = (acc_q[g] == bdlp_pkg::LEVEL_PRESSED);
		end

		// a released button never holds a running countdown
		a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
			(acc_q[g] == bdlp_pkg::LEVEL_RELEASED) |-> (cnt_q[g] == '0))
			else $error("countdown running on released button %0d", g);

		// a long flag only exists while the debounced level is pressed
		a_long_pressed: assert property (@(posedge clk) disable iff (!arst_n)
			long_q[g] |-> (acc_q[g] == bdlp_pkg::LEVEL_PRESSED))
			else $error("long flag on released button %0d", g);
	end

	// bits with no button behind them stay low
	for (genvar h = NUM_BUTTONS; h < FW; h++) begin : g_pad
		assign press_nx_vec[h]  = 1'b0;
		assign long_nx_vec[h]   = 1'b0;
		assign stable_nx_vec[h] = 1'b0;
		assign press_vis[h]     = 1'b0;
		assign long_vis[h]      = 1'b0;
		assign stable_vis[h]    = 1'b0;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tick_acc) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			press_pending_q  <= press_nx_vec;
			long_pending_q   <= long_nx_vec;
			stable_pressed_q <= stable_nx_vec;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.press_pending  = press_pending_q;
	assign res.long_pending   = long_pending_q;
	assign res.stable_pressed = stable_pressed_q;

	// an accepted tick always leaves a result behind
	a_acc_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> res_valid_q)
		else $error("accepted tick produced no result");

	// a held result mirrors the button state it was taken from
	a_res_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (press_pending_q == press_vis) && (long_pending_q == long_vis)
			&& (stable_pressed_q == stable_vis))
		else $error("result register out of step with button state");

endmodule

[verif/bdlp_flag_checker.sv]
// ----------------------------------------------------------------------------
// bdlp_flag_checker
// watches the tick, result and register ports of the debounce block, keeps
// its own copy of every button's state and compares each result in order
// ----------------------------------------------------------------------------
module bdlp_flag_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	bdlp_tick_if                           tick,
	bdlp_result_if                         res,
	input  logic                           cfg_we,
	input  logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdlp_pkg::CNT_W-1:0]     cfg_wdata,
	output int                             fail_count,
	output int                             pending,
	output int                             tick_count,
	output int                             long_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BTNS = bdlp_pkg::FIELD_W;

	typedef struct packed {
		bdlp_pkg::btn_vec_t press_pending;
		bdlp_pkg::btn_vec_t long_pending;
		bdlp_pkg::btn_vec_t stable_pressed;
	} btn_flags_t;

	btn_flags_t flags_due[$];

	bdlp_pkg::cnt_t     long_start;
	bdlp_pkg::cnt_t     long_repeat;
	bdlp_pkg::btn_vec_t smp_old;
	bdlp_pkg::btn_vec_t smp_mid;
	bdlp_pkg::btn_vec_t smp_new;
	bdlp_pkg::btn_vec_t lvl_accepted;
	bdlp_pkg::btn_vec_t press_flag;
	bdlp_pkg::btn_vec_t long_flag;
	bdlp_pkg::cnt_t     hold_left [BTNS];

	initial begin
		fail_count   = 0;
		tick_count   = 0;
		long_results = 0;
		pending      = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		btn_flags_t         want;
		btn_flags_t         got;
		bdlp_pkg::btn_vec_t pins;
		if (!arst_n) begin
			long_start   = bdlp_pkg::LONG_START_RST;
			long_repeat  = bdlp_pkg::LONG_REPEAT_RST;
			smp_old      = {BTNS{bdlp_pkg::LEVEL_RELEASED}};
			smp_mid      = {BTNS{bdlp_pkg::LEVEL_RELEASED}};
			smp_new      = {BTNS{bdlp_pkg::LEVEL_RELEASED}};
			lvl_accepted = {BTNS{bdlp_pkg::LEVEL_RELEASED}};
			press_flag   = '0;
			long_flag    = '0;
			for (int b = 0; b < BTNS; b++)
				hold_left[b] = '0;
			flags_due.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (bdlp_pkg::cfg_reg_t'(cfg_index))
					bdlp_pkg::REG_LONG_START:  long_start  = cfg_wdata;
					bdlp_pkg::REG_LONG_REPEAT: long_repeat = cfg_wdata;
					default: ;
				endcase
			end

			if (res.valid && res.ready) begin
				got = '{res.press_pending, res.long_pending, res.stable_pressed};
				if (got.long_pending != '0)
					long_results++;
				if (flags_due.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result transaction with no tick outstanding", $time);
					fail_count++;
				end else begin
					want = flags_due.pop_front();
					if (got.press_pending != want.press_pending ||
						got.long_pending != want.long_pending ||
						got.stable_pressed != want.stable_pressed) begin
						if (fail_count < 10)
							$display("%0t: mismatch press %h/%h long %h/%h stable %h/%h (exp/got)",
								$time, want.press_pending, got.press_pending,
								want.long_pending, got.long_pending,
								want.stable_pressed, got.stable_pressed);
						fail_count++;
					end
				end
			end

			if (tick.valid && tick.ready) begin
				tick_count++;
				pins = tick.pin_levels;
				for (int b = 0; b < BTNS; b++) begin
					// acks clear first, the debounce update may set again
					if (tick.press_ack[b])
						press_flag[b] = 1'b0;
					if (tick.long_ack[b])
						long_flag[b] = 1'b0;
					smp_old[b] = smp_mid[b];
					smp_mid[b] = smp_new[b];
					smp_new[b] = pins[b];
					if (smp_old[b] == smp_mid[b] && smp_mid[b] == smp_new[b]) begin
						if (lvl_accepted[b] != pins[b]) begin
							lvl_accepted[b] = pins[b];
							long_flag[b]    = 1'b0;
							if (pins[b] == bdlp_pkg::LEVEL_PRESSED) begin
								press_flag[b] = 1'b1;
								hold_left[b]  = long_start;
							end else begin
								hold_left[b] = '0;
							end
						end else if (pins[b] == bdlp_pkg::LEVEL_PRESSED &&
							hold_left[b] != '0) begin
							hold_left[b] = hold_left[b] - 1'b1;
							if (hold_left[b] == '0) begin
								long_flag[b] = 1'b1;
								hold_left[b] = long_repeat;
							end
						end
					end
				end
				flags_due.push_back('{press_flag, long_flag, ~lvl_accepted});
			end
			pending = flags_due.size();
		end
	end

endmodule

[verif/tb_button_debounce_long_press_top.sv]
// ----------------------------------------------------------------------------
// tb_button_debounce_long_press_top
// drives debounce ticks and register settings into the block with random
// gaps and stalls; the flag checker beside it predicts and compares results
// ----------------------------------------------------------------------------
module tb_button_debounce_long_press_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES     = 9;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_index;
	bdlp_pkg::cnt_t                 cfg_wdata;

	int  fail_count;
	int  pending;
	int  tick_count;
	int  long_results;
	int  settings_done;
	int  idle_cycles;
	bit  no_idle;

	bdlp_pkg::btn_vec_t held_level;
	int                 run_left [bdlp_pkg::FIELD_W];

	bdlp_tick_if   tick_ch ();
	bdlp_result_if res_ch ();

	button_debounce_long_press_top #(
		.NUM_BUTTONS(bdlp_pkg::FIELD_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	bdlp_flag_checker i_flag_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick_ch),
		.res         (res_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.pending     (pending),
		.tick_count  (tick_count),
		.long_results(long_results)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// result side stalls
	initial begin
		int stall_left;
		int run_len;
		res_ch.ready = 1'b0;
		stall_left   = 0;
		run_len      = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (run_len == 0) begin
				stall_left = pick_gap();
				run_len    = stall_left + $urandom_range(1, 20);
			end
			res_ch.ready = (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
			run_len--;
		end
	end

	// a cycle with no transaction on either side counts towards the limit
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// called and returns at a falling edge
	task automatic push_tick(input bdlp_pkg::btn_vec_t pins, input bdlp_pkg::btn_vec_t pack,
		input bdlp_pkg::btn_vec_t lack);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			tick_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_ch.pin_levels = pins;
		tick_ch.press_ack  = pack;
		tick_ch.long_ack   = lack;
		tick_ch.valid      = 1'b1;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_hold_times(input bdlp_pkg::cnt_t start_val,
		input bdlp_pkg::cnt_t rpt_val);
		tick_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = bdlp_pkg::REG_LONG_START;
		cfg_wdata = start_val;
		@(negedge clk);
		cfg_index = bdlp_pkg::REG_LONG_REPEAT;
		cfg_wdata = rpt_val;
		@(negedge clk);
		cfg_we = 1'b0;
		settings_done++;
	endtask

	// each button holds a level for a run of ticks; short runs are bounce
	task automatic run_button_traffic(input int n_items);
		bdlp_pkg::btn_vec_t pins;
		bdlp_pkg::btn_vec_t pack;
		bdlp_pkg::btn_vec_t lack;
		int                 pick;
		for (int i = 0; i < n_items; i++) begin
			for (int b = 0; b < bdlp_pkg::FIELD_W; b++) begin
				if (run_left[b] == 0) begin
					held_level[b] = ~held_level[b];
					pick = $urandom_range(0, 99);
					if (pick < 25)
						run_left[b] = $urandom_range(1, 2);
					else if (pick < 85)
						run_left[b] = $urandom_range(3, 25);
					else
						run_left[b] = $urandom_range(26, 80);
				end
				run_left[b]--;
			end
			pins = ($urandom_range(0, 9) == 0) ? bdlp_pkg::btn_vec_t'($urandom) : held_level;
			pack = bdlp_pkg::btn_vec_t'($urandom & $urandom & $urandom);
			lack = bdlp_pkg::btn_vec_t'($urandom & $urandom & $urandom);
			if ($urandom_range(0, 19) == 0)
				pack = '1;
			if ($urandom_range(0, 19) == 0)
				lack = '1;
			push_tick(pins, pack, lack);
		end
	endtask

	initial begin
		bdlp_pkg::cnt_t start_set [PHASES];
		bdlp_pkg::cnt_t rpt_set [PHASES];
		start_set = '{16'd1, 16'd65535, 16'd0, 16'd2, 16'd0, 16'd7, 16'd3, 16'd12, 16'd100};
		rpt_set   = '{16'd1, 16'd65535, 16'd0, 16'd0, 16'd3, 16'd4, 16'd1, 16'd9, 16'd50};

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = bdlp_pkg::REG_LONG_START;
		cfg_wdata          = '0;
		tick_ch.valid      = 1'b0;
		tick_ch.pin_levels = '1;
		tick_ch.press_ack  = '0;
		tick_ch.long_ack   = '0;
		no_idle            = 1'b0;
		settings_done      = 0;
		idle_cycles        = 0;
		held_level         = '1;
		for (int b = 0; b < bdlp_pkg::FIELD_W; b++)
			run_left[b] = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset hold times: press, ack and bounce
		push_tick(4'hF, 4'h0, 4'h0);
		push_tick(4'h0, 4'h0, 4'h0);
		push_tick(4'h0, 4'h0, 4'h0);
		push_tick(4'h0, 4'h0, 4'h0);
		push_tick(4'h0, 4'hF, 4'h0);
		push_tick(4'h5, 4'h0, 4'hF);
		push_tick(4'hA, 4'h0, 4'h0);
		push_tick(4'h6, 4'h0, 4'h0);
		push_tick(4'hF, 4'hF, 4'hF);
		push_tick(4'hF, 4'h0, 4'h0);
		push_tick(4'hF, 4'h0, 4'h0);

		// short hold: long-press, repeat, ack in the same tick as a new event
		write_hold_times(16'd2, 16'd1);
		push_tick(4'h0, 4'h0, 4'h0);
		push_tick(4'h0, 4'h0, 4'h0);
		push_tick(4'h0, 4'h0, 4'h0);
		push_tick(4'h0, 4'hF, 4'h0);
		push_tick(4'h0, 4'h0, 4'h0);
		push_tick(4'h0, 4'h0, 4'hF);
		push_tick(4'h9, 4'h0, 4'h0);
		push_tick(4'h9, 4'h0, 4'h0);
		push_tick(4'h9, 4'h0, 4'h6);
		push_tick(4'h0, 4'h0, 4'h0);
		push_tick(4'h0, 4'h0, 4'h0);
		push_tick(4'h0, 4'h9, 4'h0);
		push_tick(4'h0, 4'h0, 4'h0);
		push_tick(4'hF, 4'h0, 4'h0);

		for (int p = 0; p < PHASES; p++) begin
			write_hold_times(start_set[p], rpt_set[p]);
			no_idle = (p % 4 == 1);
			run_button_traffic(96);
		end
		no_idle = 1'b0;

		tick_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("covered %0d ticks under %0d hold-time settings", tick_count, settings_done);
		$display("%0d results carried a long-press flag", long_results);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
rtl/core/bdlp_pkg.sv
rtl/core/bdlp_if.sv
rtl/core/button_debounce_long_press_top.sv
verif/bdlp_flag_checker.sv
verif/tb_button_debounce_long_press_top.sv
